// File: design/rspg_pkg.sv
// Shared types, constants and tables for the raster scan point generator.
// Used by the controller, the datapath and the top level; no dependencies.
package rspg_pkg;

  localparam int FINE_STEPS      = 10;
  localparam int MAX_BARS        = 64;
  localparam int ANGLE_FRAC_BITS = 7;
  localparam int CORDIC_STEPS    = 16;

  localparam int IDX_W  = 6;   // column and row index
  localparam int FINE_W = 4;   // fine step index
  localparam int DIV_W  = 27;  // dividend and quotient bits
  localparam int DVS_W  = 11;  // divisor bits
  localparam int QUO_W  = 23;  // quotient bits that can be nonzero
  localparam int ANG_W  = 26;  // angle work register
  localparam int XY_W   = 33;  // CORDIC x and y
  localparam int SAT_W  = 23;  // rounded value before saturation
  localparam int CNT_W  = 5;   // step counter

  localparam int FULL_TURN   = 360 << ANGLE_FRAC_BITS;
  localparam int HALF_TURN   = 180 << ANGLE_FRAC_BITS;
  localparam int FINE_SHIFT  = 16 - ANGLE_FRAC_BITS;
  localparam int DEG90       = 5898240;
  localparam int DEG180      = 11796480;
  localparam int CORDIC_GAIN = 652032874;
  localparam int RED_LAST    = 9;   // offset, eight subtractions, half-turn fold
  localparam int RED_TOP     = 8;   // first subtraction uses FULL_TURN << 7

  typedef enum logic [2:0] {
    CFG_AZ_CENTER   = 3'd0,
    CFG_EL_CENTER   = 3'd1,
    CFG_AZ_WIDTH    = 3'd2,
    CFG_EL_HEIGHT   = 3'd3,
    CFG_BAR_COUNT   = 3'd4
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_DIVL, ST_DIV, ST_ANG, ST_RED,
    ST_CORL, ST_CORD, ST_CSAV, ST_PROD, ST_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_RESTART, OP_MUL, OP_DIV_LOAD, OP_DIV_STEP, OP_ANG,
    OP_RED_STEP, OP_COR_LOAD, OP_COR_STEP, OP_COR_SAVE, OP_PROD, OP_WRITE
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   sel_el;   // 0: azimuth pass, 1: elevation pass
  } dp_cmd_t;

  typedef struct packed {
    logic step_last;
    logic out_busy;
  } dp_status_t;

  // CORDIC arctangent table in 2^-16 degree
  function automatic logic [21:0] atan_val(input logic [3:0] n);
    logic [21:0] v;
    case (n)
      4'd0:    v = 22'd2949120;
      4'd1:    v = 22'd1740967;
      4'd2:    v = 22'd919879;
      4'd3:    v = 22'd466945;
      4'd4:    v = 22'd234379;
      4'd5:    v = 22'd117304;
      4'd6:    v = 22'd58666;
      4'd7:    v = 22'd29335;
      4'd8:    v = 22'd14668;
      4'd9:    v = 22'd7334;
      4'd10:   v = 22'd3667;
      4'd11:   v = 22'd1833;
      4'd12:   v = 22'd917;
      4'd13:   v = 22'd458;
      4'd14:   v = 22'd229;
      default: v = 22'd115;
    endcase
    return v;
  endfunction

  // Clamp to the Q1.15 range
  function automatic logic signed [15:0] sat16(input logic signed [SAT_W-1:0] v);
    logic signed [15:0] r;
    if (v > SAT_W'(32767)) r = 16'sh7fff;
    else if (v < -SAT_W'(32768)) r = 16'sh8000;
    else r = 16'(v);
    return r;
  endfunction

endpackage

// File: design/raster_scan_point_generator_top.sv
// Top level of the raster scan point generator.
// Depends on rspg_pkg, rspg_ctrl and rspg_datapath.
//
// Each item with advance set yields the next raster scan pointing direction
// as a Q1.15 unit vector plus column and frame end flags; an item with
// advance clear restarts the scan at the first point and gives no result.
// For each of the two angles in turn, a load step sets up one shared
// bit-serial divider, which then runs; the angle sum is formed, the modulo-360
// reduction runs, and the iterative CORDIC is loaded, runs and saves its
// sine and cosine. A multiply comes before the two angles; the products
// and the write follow. One item is in work at a time and the input
// stalls until its point is written. The write waits while an earlier
// result sits stalled in the output register. The finished result waits
// there while the next item runs.
// Configuration writes are always ready and take effect at once.
module raster_scan_point_generator_top
  import rspg_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_advance,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_dir_x,
  output logic signed [15:0] out_dir_y,
  output logic signed [15:0] out_dir_z,
  output logic               out_column_done,
  output logic               out_frame_done,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);

  dp_cmd_t    cmd;
  dp_status_t status;

  rspg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_advance (in_advance),
    .in_stall   (in_stall),
    .status     (status),
    .cmd        (cmd)
  );

  rspg_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_dir_x       (out_dir_x),
    .out_dir_y       (out_dir_y),
    .out_dir_z       (out_dir_z),
    .out_column_done (out_column_done),
    .out_frame_done  (out_frame_done)
  );

endmodule

// File: design/rspg_ctrl.sv
// Sequencer for the raster scan point generator.
// Depends on rspg_pkg; drives commands to rspg_datapath.
module rspg_ctrl
  import rspg_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_advance,
  output logic       in_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state_r, state_nxt;
  logic   sel_el_r;

  // State and pass select
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      sel_el_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_MUL) sel_el_r <= 1'b0;
      else if (state_r == ST_CSAV) sel_el_r <= 1'b1;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid && in_advance) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_DIVL;
      ST_DIVL: state_nxt = ST_DIV;
      ST_DIV:  if (status.step_last) state_nxt = ST_ANG;
      ST_ANG:  state_nxt = ST_RED;
      ST_RED:  if (status.step_last) state_nxt = ST_CORL;
      ST_CORL: state_nxt = ST_CORD;
      ST_CORD: if (status.step_last) state_nxt = ST_CSAV;
      ST_CSAV: state_nxt = sel_el_r ? ST_PROD : ST_DIVL;
      ST_PROD: state_nxt = ST_OUT;
      ST_OUT:  if (!status.out_busy) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    in_stall   = 1'b1;
    cmd.op     = OP_NONE;
    cmd.sel_el = sel_el_r;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) cmd.op = in_advance ? OP_MUL : OP_RESTART;
      end
      ST_MUL:  cmd.op = OP_NONE;
      ST_DIVL: cmd.op = OP_DIV_LOAD;
      ST_DIV:  cmd.op = OP_DIV_STEP;
      ST_ANG:  cmd.op = OP_ANG;
      ST_RED:  cmd.op = OP_RED_STEP;
      ST_CORL: cmd.op = OP_COR_LOAD;
      ST_CORD: cmd.op = OP_COR_STEP;
      ST_CSAV: cmd.op = OP_COR_SAVE;
      ST_PROD: cmd.op = OP_PROD;
      ST_OUT:  cmd.op = status.out_busy ? OP_NONE : OP_WRITE;
      default: cmd.op = OP_NONE;
    endcase
  end

endmodule

// File: design/rspg_datapath.sv
// Datapath: config registers, scan indices, shared divider, angle reduction,
// iterative CORDIC, products and output register. Depends on rspg_pkg.
module rspg_datapath
  import rspg_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            cmd,
  output dp_status_t         status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_dir_x,
  output logic signed [15:0] out_dir_y,
  output logic signed [15:0] out_dir_z,
  output logic               out_column_done,
  output logic               out_frame_done
);

  logic signed [15:0] az_center_r;
  logic signed [14:0] el_center_r;
  logic [15:0]        az_width_r;
  logic [14:0]        el_height_r;
  logic [6:0]         bar_count_r;
  logic [IDX_W-1:0]   col_r, row_r;
  logic [FINE_W-1:0]  fine_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [DIV_W-1:0]   az_prod_r, el_prod_r, quo_r;
  logic               az_neg_r, el_neg_r;
  logic [DVS_W-1:0]   rem_r, dvs_r;
  logic signed [ANG_W-1:0] ang_r, z_r;
  logic signed [XY_W-1:0]  x_r, y_r;
  logic                    fold_r;
  logic signed [XY_W-1:0]  cos_az_r, sin_az_r, cos_el_r, sin_el_r;
  logic signed [2*XY_W-1:0] px_r, py_r;
  logic                     out_valid_r;

  // Effective last index from the bar count
  logic [IDX_W-1:0] last_c;
  always_comb begin
    if (bar_count_r < 7'd2) last_c = IDX_W'(1);
    else if (bar_count_r > 7'(MAX_BARS)) last_c = IDX_W'(MAX_BARS - 1);
    else last_c = IDX_W'(bar_count_r - 7'd1);
  end

  // Signed offsets of this point from the scan center, in grid units
  int               az_t, el_t;
  logic [DVS_W-1:0] az_mag, el_mag;
  always_comb begin
    az_t = 2 * (int'(col_r) * FINE_STEPS + int'(fine_r)) - int'(last_c) * FINE_STEPS;
    el_t = 2 * int'(row_r) - int'(last_c);
    az_mag = DVS_W'(az_t < 0 ? -az_t : az_t);
    el_mag = DVS_W'(el_t < 0 ? -el_t : el_t);
  end

  // Divider step
  logic [DVS_W:0]   rem_sh, rem_sub;
  logic             qbit;
  always_comb begin
    rem_sh  = {rem_r, quo_r[DIV_W-1]};
    rem_sub = rem_sh - {1'b0, dvs_r};
    qbit    = (rem_sh >= {1'b0, dvs_r});
  end

  // Angle and reduction terms
  logic signed [ANG_W-1:0] center_c, q_c, full_sh, zs, cx, cy;
  logic [2:0]              red_s;
  logic [3:0]              cn;
  always_comb begin
    center_c = cmd.sel_el ? ANG_W'(el_center_r) : ANG_W'(az_center_r);
    q_c      = signed'(ANG_W'(quo_r[QUO_W-1:0]));
    if (cmd.sel_el ? el_neg_r : az_neg_r) q_c = -q_c;
    red_s    = 3'(4'(RED_TOP) - cnt_r[3:0]);
    full_sh  = ANG_W'(FULL_TURN) <<< red_s;
    zs       = ang_r <<< FINE_SHIFT;
    cn       = cnt_r[3:0];
    cx       = signed'(ANG_W'(atan_val(cn)));
    cy       = cx;
  end

  // Rounding of the output components
  logic [2*XY_W-1:0] mx, my;
  logic [XY_W-1:0]   mz;
  logic [SAT_W-2:0]  rx, ry, rz;
  logic signed [SAT_W-1:0] vx, vy, vz;
  always_comb begin
    mx = px_r[2*XY_W-1] ? unsigned'(-px_r) : unsigned'(px_r);
    my = py_r[2*XY_W-1] ? unsigned'(-py_r) : unsigned'(py_r);
    mz = sin_el_r[XY_W-1] ? unsigned'(-sin_el_r) : unsigned'(sin_el_r);
    rx = (SAT_W-1)'((mx + ((2*XY_W)'(1) << 44)) >> 45);
    ry = (SAT_W-1)'((my + ((2*XY_W)'(1) << 44)) >> 45);
    rz = (SAT_W-1)'((mz + XY_W'(1 << 14)) >> 15);
    vx = px_r[2*XY_W-1] ? signed'({1'b0, rx}) : -signed'({1'b0, rx});
    vy = py_r[2*XY_W-1] ? signed'({1'b0, ry}) : -signed'({1'b0, ry});
    vz = sin_el_r[XY_W-1] ? -signed'({1'b0, rz}) : signed'({1'b0, rz});
  end

  // Scan position flags
  logic fine_last, row_last, col_last, col_end;
  always_comb begin
    fine_last = (fine_r >= FINE_W'(FINE_STEPS - 1));
    row_last  = (row_r >= last_c);
    col_last  = (col_r >= last_c);
    col_end   = fine_last && row_last;
  end

  // Status to the controller
  always_comb begin
    status.out_busy  = out_valid_r && out_stall;
    status.step_last = ((cmd.op == OP_DIV_STEP) && (cnt_r == CNT_W'(DIV_W - 1))) ||
                       ((cmd.op == OP_RED_STEP) && (cnt_r == CNT_W'(RED_LAST))) ||
                       ((cmd.op == OP_COR_STEP) && (cnt_r == CNT_W'(CORDIC_STEPS - 1)));
  end

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      az_center_r <= '0;
      el_center_r <= '0;
      az_width_r  <= 16'd1280;
      el_height_r <= 15'd1280;
      bar_count_r <= 7'd4;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_AZ_CENTER: az_center_r <= cfg_wdata;
        CFG_EL_CENTER: el_center_r <= cfg_wdata[14:0];
        CFG_AZ_WIDTH:  az_width_r  <= cfg_wdata;
        CFG_EL_HEIGHT: el_height_r <= cfg_wdata[14:0];
        CFG_BAR_COUNT: bar_count_r <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  // Indices and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      fine_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == OP_WRITE) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (cmd.op == OP_RESTART) begin
        col_r  <= '0;
        row_r  <= '0;
        fine_r <= '0;
      end else if (cmd.op == OP_WRITE) begin
        if (fine_last) begin
          fine_r <= '0;
          if (row_last) begin
            row_r <= '0;
            col_r <= col_last ? '0 : col_r + IDX_W'(1);
          end else begin
            row_r <= row_r + IDX_W'(1);
          end
        end else begin
          fine_r <= fine_r + FINE_W'(1);
        end
      end
    end
  end

  // Arithmetic work registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_MUL: begin
        az_prod_r <= DIV_W'(az_mag) * DIV_W'(az_width_r);
        el_prod_r <= DIV_W'(el_mag) * DIV_W'(el_height_r);
        az_neg_r  <= (az_t < 0);
        el_neg_r  <= (el_t < 0);
      end
      OP_DIV_LOAD: begin
        cnt_r <= '0;
        rem_r <= '0;
        if (cmd.sel_el) begin
          quo_r <= el_prod_r + DIV_W'(last_c);
          dvs_r <= DVS_W'({last_c, 1'b0});
        end else begin
          quo_r <= az_prod_r + DIV_W'(last_c * FINE_STEPS);
          dvs_r <= DVS_W'(last_c * (2 * FINE_STEPS));
        end
      end
      OP_DIV_STEP: begin
        cnt_r <= cnt_r + CNT_W'(1);
        rem_r <= qbit ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        quo_r <= {quo_r[DIV_W-2:0], qbit};
      end
      OP_ANG: begin
        cnt_r <= '0;
        ang_r <= center_c + q_c;
      end
      OP_RED_STEP: begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == '0) begin
          if (ang_r < 0) ang_r <= ang_r + (ANG_W'(FULL_TURN) <<< 7);
        end else if (cnt_r == CNT_W'(RED_LAST)) begin
          if (ang_r >= ANG_W'(HALF_TURN)) ang_r <= ang_r - ANG_W'(FULL_TURN);
        end else if (ang_r >= full_sh) begin
          ang_r <= ang_r - full_sh;
        end
      end
      OP_COR_LOAD: begin
        cnt_r <= '0;
        x_r   <= XY_W'(CORDIC_GAIN);
        y_r   <= '0;
        if (zs > ANG_W'(DEG90)) begin
          z_r <= zs - ANG_W'(DEG180);
          fold_r <= 1'b1;
        end else if (zs < -ANG_W'(DEG90)) begin
          z_r <= zs + ANG_W'(DEG180);
          fold_r <= 1'b1;
        end else begin
          z_r <= zs;
          fold_r <= 1'b0;
        end
      end
      OP_COR_STEP: begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (z_r >= 0) begin
          x_r <= x_r - (y_r >>> cn);
          y_r <= y_r + (x_r >>> cn);
          z_r <= z_r - cx;
        end else begin
          x_r <= x_r + (y_r >>> cn);
          y_r <= y_r - (x_r >>> cn);
          z_r <= z_r + cy;
        end
      end
      OP_COR_SAVE: begin
        if (cmd.sel_el) begin
          cos_el_r <= fold_r ? -x_r : x_r;
          sin_el_r <= fold_r ? -y_r : y_r;
        end else begin
          cos_az_r <= fold_r ? -x_r : x_r;
          sin_az_r <= fold_r ? -y_r : y_r;
        end
      end
      OP_PROD: begin
        px_r <= cos_az_r * cos_el_r;
        py_r <= sin_az_r * cos_el_r;
      end
      OP_WRITE: begin
        out_dir_x       <= sat16(vx);
        out_dir_y       <= sat16(vy);
        out_dir_z       <= sat16(vz);
        out_column_done <= col_end;
        out_frame_done  <= col_end && col_last;
      end
      default: ;
    endcase
  end

endmodule

// File: design/rspg_checker.sv
// Port-level checks for the raster scan point generator.
// Bound to raster_scan_point_generator_top; no package dependency.
module rspg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_advance,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_dir_x,
  input logic        out_column_done,
  input logic        out_frame_done
);

  // Busy after taking an advance item
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_advance |=> in_stall)
    else $error("input not stalled while a point is in work");

  // Frame end only on a column end
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_done |-> out_column_done)
    else $error("frame end without column end");

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_dir_x))
    else $error("stalled result changed");

  // Come out of reset idle and empty
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("not idle after reset");

endmodule

bind raster_scan_point_generator_top rspg_checker u_rspg_checker (.*);
